[design/dts_pkg.sv]
// Shared constants for the deadline timer scheduler: operation codes,
// sequencer state codes and fixed field widths. No dependencies.
package dts_pkg;

   localparam int IdW    = 4;
   localparam int TimeW  = 64;
   localparam int PerW   = 32;
   localparam int IntW   = 20;
   localparam int CsrIdxW = 4;

   localparam logic [1:0] FUNC_SCHED  = 2'd0;
   localparam logic [1:0] FUNC_CANCEL = 2'd1;
   localparam logic [1:0] FUNC_CHECK  = 2'd2;
   localparam logic [1:0] FUNC_NOP    = 2'd3;

   localparam logic [CsrIdxW-1:0] REG_INT_MIN = 4'd0;
   localparam logic [CsrIdxW-1:0] REG_INT_MAX = 4'd1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DEQ   = 3'd1;
   localparam logic [2:0] ST_INS   = 3'd2;
   localparam logic [2:0] ST_FHEAD = 3'd3;
   localparam logic [2:0] ST_DELTA = 3'd4;
   localparam logic [2:0] ST_STAT  = 3'd5;

   localparam logic [IntW-1:0] INT_MIN_RST = 20'd50;
   localparam logic [IntW-1:0] INT_MAX_RST = 20'd50000;

endpackage

[design/deadline_timer_scheduler.sv]
// Deadline timer scheduler: sorted timer queue walked by one sequencer.
// Schedule, cancel and each check firing walk the sorted list; each result
//   waits for a free output register.
// Throughput: one item at a time; req_stall is high until the last result
//   of the item is loaded. The list walk (one slot per cycle) sets the rate.
// Reset (synchronous, active high): queue empty, all entries idle,
//   interval_min 50 us, interval_max 50000 us. Depends on dts_pkg.
module deadline_timer_scheduler
   import dts_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int FIRE_LIMIT = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [IdW-1:0]     req_entry_id,
   input  logic [TimeW-1:0]   req_due_time,
   input  logic [PerW-1:0]    req_repeat_period,
   input  logic [TimeW-1:0]   req_now_us,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_fired,
   output logic [IdW-1:0]     rsp_fired_entry,
   output logic               rsp_entry_idle,
   output logic               rsp_wake_enabled,
   output logic [IntW-1:0]    rsp_wake_delay,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [IntW-1:0]    csr_data
);

   localparam int IW = $clog2(ENTRIES);
   localparam int LW = $clog2(ENTRIES + 1);
   localparam int NW = $clog2(FIRE_LIMIT + 1);

   // entry state
   logic [TimeW-1:0] dl_ff  [ENTRIES];
   logic [PerW-1:0]  per_ff [ENTRIES];
   logic [ENTRIES-1:0] q_ff;
   logic [IW-1:0]    ord_ff [ENTRIES];
   logic [LW-1:0]    len_ff;
   logic [IntW-1:0]  imin_ff, imax_ff;

   // sequencer
   logic [2:0]       st_ff;
   logic [1:0]       func_ff;
   logic [IW-1:0]    id_ff;
   logic             idv_ff;
   logic [TimeW-1:0] due_ff, now_ff, tdl_ff, delta_ff;
   logic [PerW-1:0]  per_in_ff;
   logic [IW-1:0]    tgt_ff;
   logic [LW-1:0]    walk_ff;
   logic             found_ff;
   logic [NW-1:0]    n_ff;

   // output register
   logic             ov_ff, ofired_ff, oidle_ff, owen_ff, olast_ff;
   logic [IdW-1:0]   oent_ff;
   logic [IntW-1:0]  odelay_ff;

   logic             slot_free;
   logic             fire_go, ov_load;
   logic [LW-1:0]    walk_p1, walk_m1;
   logic [IW-1:0]    head, prev_id, cur_id;
   logic             hit;
   logic [TimeW-1:0] head_dl, prev_dl;
   logic [TimeW:0]   rearm;

   assign slot_free = !ov_ff || !rsp_stall;
   assign walk_p1   = walk_ff + LW'(1);
   assign walk_m1   = walk_ff - LW'(1);
   assign head      = ord_ff[0];
   assign head_dl   = dl_ff[head];
   assign cur_id    = ord_ff[walk_ff[IW-1:0]];
   assign prev_id   = ord_ff[walk_m1[IW-1:0]];
   assign prev_dl   = dl_ff[prev_id];
   assign hit       = found_ff || (cur_id == tgt_ff);
   assign rearm     = {1'b0, dl_ff[tgt_ff]} + {{(TimeW+1-PerW){1'b0}}, per_ff[tgt_ff]};

   // load the output register with a firing or with the status result
   assign fire_go   = (st_ff == ST_FHEAD) && (len_ff != '0) &&
                      (n_ff != NW'(FIRE_LIMIT)) && !(head_dl > now_ff) && slot_free;
   assign ov_load   = fire_go || ((st_ff == ST_STAT) && slot_free);

   assign req_stall = (st_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // interval registers written at config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         imin_ff <= INT_MIN_RST;
         imax_ff <= INT_MAX_RST;
      end else if (csr_valid) begin
         if (csr_index == REG_INT_MIN) imin_ff <= csr_data;
         if (csr_index == REG_INT_MAX) imax_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         q_ff   <= '0;
         len_ff <= '0;
         ov_ff  <= 1'b0;
         n_ff   <= '0;
         for (int k = 0; k < ENTRIES; k++) begin
            dl_ff[k]  <= '0;
            per_ff[k] <= '0;
         end
      end else begin
         if (ov_load) ov_ff <= 1'b1;
         else if (ov_ff && !rsp_stall) ov_ff <= 1'b0;
         case (st_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  func_ff   <= req_func;
                  id_ff     <= IW'(req_entry_id);
                  idv_ff    <= ({{(32-IdW){1'b0}}, req_entry_id} < 32'(ENTRIES));
                  due_ff    <= req_due_time;
                  per_in_ff <= req_repeat_period;
                  now_ff    <= req_now_us;
                  tgt_ff    <= IW'(req_entry_id);
                  walk_ff   <= '0;
                  found_ff  <= 1'b0;
                  n_ff      <= '0;
                  if ((req_func == FUNC_SCHED || req_func == FUNC_CANCEL) &&
                      ({{(32-IdW){1'b0}}, req_entry_id} < 32'(ENTRIES)))
                     st_ff <= ST_DEQ;
                  else if (req_func == FUNC_CHECK)
                     st_ff <= ST_FHEAD;
                  else
                     st_ff <= ST_DELTA;
               end
            end
            ST_DEQ: begin
               // close the gap left by the target, one slot a cycle
               if (q_ff[tgt_ff] && hit && (walk_p1 < len_ff))
                  ord_ff[walk_ff[IW-1:0]] <= ord_ff[walk_p1[IW-1:0]];
               if (!q_ff[tgt_ff] || (walk_p1 >= len_ff)) begin
                  if (q_ff[tgt_ff]) begin
                     len_ff       <= len_ff - LW'(1);
                     q_ff[tgt_ff] <= 1'b0;
                     walk_ff      <= len_ff - LW'(1);
                  end else begin
                     walk_ff <= len_ff;
                  end
                  case (func_ff)
                     FUNC_SCHED: begin
                        dl_ff[tgt_ff]  <= due_ff;
                        per_ff[tgt_ff] <= per_in_ff;
                        tdl_ff         <= due_ff;
                        st_ff          <= ST_INS;
                     end
                     FUNC_CANCEL: begin
                        dl_ff[tgt_ff]  <= '0;
                        per_ff[tgt_ff] <= '0;
                        st_ff          <= ST_DELTA;
                     end
                     default: begin
                        // re-arm a periodic entry, saturating on overflow
                        if (per_ff[tgt_ff] != '0) begin
                           dl_ff[tgt_ff] <= rearm[TimeW] ? '1 : rearm[TimeW-1:0];
                           tdl_ff        <= rearm[TimeW] ? '1 : rearm[TimeW-1:0];
                           st_ff         <= ST_INS;
                        end else begin
                           dl_ff[tgt_ff] <= '0;
                           st_ff         <= ST_FHEAD;
                        end
                     end
                  endcase
               end else begin
                  walk_ff  <= walk_p1;
                  found_ff <= hit;
               end
            end
            ST_INS: begin
               // walk from the tail, shift later deadlines up by one
               if ((walk_ff != '0) && (prev_dl > tdl_ff)) begin
                  ord_ff[walk_ff[IW-1:0]] <= prev_id;
                  walk_ff <= walk_m1;
               end else begin
                  ord_ff[walk_ff[IW-1:0]] <= tgt_ff;
                  q_ff[tgt_ff] <= 1'b1;
                  len_ff       <= len_ff + LW'(1);
                  st_ff        <= (func_ff == FUNC_CHECK) ? ST_FHEAD : ST_DELTA;
               end
            end
            ST_FHEAD: begin
               if ((len_ff == '0) || (n_ff == NW'(FIRE_LIMIT)) || (head_dl > now_ff)) begin
                  st_ff <= ST_DELTA;
               end else if (slot_free) begin
                  ofired_ff <= 1'b1;
                  oent_ff   <= IdW'(head);
                  oidle_ff  <= (per_ff[head] == '0);
                  owen_ff   <= 1'b0;
                  odelay_ff <= '0;
                  olast_ff  <= 1'b0;
                  n_ff      <= n_ff + NW'(1);
                  tgt_ff    <= head;
                  walk_ff   <= '0;
                  found_ff  <= 1'b0;
                  st_ff     <= ST_DEQ;
               end
            end
            ST_DELTA: begin
               delta_ff <= (head_dl > now_ff) ? head_dl - now_ff : '0;
               st_ff    <= ST_STAT;
            end
            ST_STAT: begin
               if (slot_free) begin
                  ofired_ff <= 1'b0;
                  oent_ff   <= '0;
                  oidle_ff  <= idv_ff ? !q_ff[id_ff] : 1'b1;
                  owen_ff   <= (len_ff != '0);
                  olast_ff  <= 1'b1;
                  if (len_ff == '0)
                     odelay_ff <= '0;
                  else if (delta_ff <= {{(TimeW-IntW){1'b0}}, imin_ff})
                     odelay_ff <= imin_ff;
                  else if (delta_ff < {{(TimeW-IntW){1'b0}}, imax_ff})
                     odelay_ff <= delta_ff[IntW-1:0];
                  else
                     odelay_ff <= imax_ff;
                  st_ff <= ST_IDLE;
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid        = ov_ff;
   assign rsp_fired        = ofired_ff;
   assign rsp_fired_entry  = oent_ff;
   assign rsp_entry_idle   = oidle_ff;
   assign rsp_wake_enabled = owen_ff;
   assign rsp_wake_delay   = odelay_ff;
   assign rsp_last         = olast_ff;

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("busy not raised");
   a_len: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(ENTRIES)) else $error("queue overrun");
   a_nlim: assert property (@(posedge clock) disable iff (reset)
      n_ff <= NW'(FIRE_LIMIT)) else $error("fire limit overrun");
   a_fire: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired |-> !rsp_wake_enabled && !rsp_last)
      else $error("firing item carries status");

endmodule
